### rtl/ric_pkg.sv
`default_nettype none

package ric_pkg;

  localparam logic [1:0] ACT_GET     = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_MARK    = 2'd2;

  localparam logic [2:0] ST_HIT     = 3'd0;
  localparam logic [2:0] ST_MISS    = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_RELEASE = 3'd3;
  localparam logic [2:0] ST_RECLAIM = 3'd4;
  localparam logic [2:0] ST_ERR_MRK = 3'd5;

  localparam logic [15:0] REFS_MAX = 16'hFFFF;

  // request token walking down the row of entries
  typedef struct packed {
    logic        valid;
    logic [1:0]  action;
    logic [31:0] inum;
    logic [5:0]  slot;
    logic        links_zero;
    logic        done;        // hit found
    logic        free_found;  // a free entry has been reserved
    logic [5:0]  res_slot;
    logic [2:0]  res_status;
    logic        res_nl;
    logic [15:0] res_refs;
  } ric_tok_t;

  // claim of the reserved free entry after a missing get
  typedef struct packed {
    logic        en;
    logic [31:0] tag;
  } ric_commit_t;

endpackage

`default_nettype wire

### rtl/ric_cell.sv
`default_nettype none

module ric_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  ric_pkg::ric_tok_t    tok_i,
  input  ric_pkg::ric_commit_t commit_i,
  output ric_pkg::ric_tok_t    tok_o
);
  import ric_pkg::*;

  localparam logic [5:0] SLOT = 6'(IDX);

  logic [31:0] tag_q, tag_d;
  logic [15:0] refs_q, refs_d;
  logic        loaded_q, loaded_d;
  logic        reserve_q, reserve_d;
  ric_tok_t    tok_q, tok_d;
  logic        hit;
  logic        sel;

  assign hit = (refs_q != 16'd0) && (tag_q == tok_i.inum);
  assign sel = (32'(tok_i.slot) == 32'(IDX));

  always_comb begin
    tok_d     = tok_i;
    tag_d     = tag_q;
    refs_d    = refs_q;
    loaded_d  = loaded_q;
    reserve_d = reserve_q;
    if (tok_i.valid) begin
      unique case (tok_i.action)
        ACT_GET: begin
          reserve_d = 1'b0;
          if (!tok_i.done) begin
            if (hit) begin
              refs_d = (refs_q == REFS_MAX) ? refs_q : refs_q + 16'd1;
              tok_d.done       = 1'b1;
              tok_d.res_slot   = SLOT;
              tok_d.res_status = ST_HIT;
              tok_d.res_nl     = ~loaded_q;
              tok_d.res_refs   = refs_d;
            end else if (!tok_i.free_found && refs_q == 16'd0) begin
              reserve_d        = 1'b1;
              tok_d.free_found = 1'b1;
              tok_d.res_slot   = SLOT;
              tok_d.res_status = ST_MISS;
              tok_d.res_nl     = 1'b1;
              tok_d.res_refs   = 16'd1;
            end
          end
        end
        ACT_RELEASE: begin
          if (sel && refs_q != 16'd0) begin
            refs_d = refs_q - 16'd1;
            if (refs_d == 16'd0 && loaded_q && tok_i.links_zero) begin
              tok_d.res_status = ST_RECLAIM;
              tok_d.res_nl     = 1'b0;
              tok_d.res_refs   = 16'd0;
            end else begin
              tok_d.res_status = ST_RELEASE;
              tok_d.res_nl     = ~loaded_q;
              tok_d.res_refs   = refs_d;
            end
          end
        end
        ACT_MARK: begin
          if (sel) begin
            loaded_d       = 1'b1;
            tok_d.res_nl   = 1'b0;
            tok_d.res_refs = refs_q;
          end
        end
        default: ;
      endcase
    end
    if (commit_i.en && reserve_q) begin
      tag_d     = commit_i.tag;
      refs_d    = 16'd1;
      loaded_d  = 1'b0;
      reserve_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q     <= '0;
      refs_q    <= '0;
      loaded_q  <= 1'b0;
      reserve_q <= 1'b0;
      tok_q     <= '0;
    end else begin
      tag_q     <= tag_d;
      refs_q    <= refs_d;
      loaded_q  <= loaded_d;
      reserve_q <= reserve_d;
      tok_q     <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

### rtl/refcounted_inode_cache_table_unit.sv
// The request token walks the row of entry cells one cell per cycle, then a tail register,
// then the output register, which loads once the output is free or taken. One request is in
// flight at a time: a new request is taken only after the last one has left the tail register.
// Reset: asynchronous, active low; all entries come out free, untagged, not loaded.
`default_nettype none

module refcounted_inode_cache_table_unit #(
  parameter int unsigned CACHE_ENTRIES = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [39:0] s_axis_tdata_i,  // inode_number[31:0], entry_slot[37:32], links_zero[38]
  input  wire  [1:0]  s_axis_tuser_i,  // action
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // result_slot[5:0], needs_load[6], ref_after[22:7]
  output logic [2:0]  m_axis_tuser_o   // status
);
  import ric_pkg::*;

  ric_tok_t    chain [CACHE_ENTRIES+1];
  ric_tok_t    tok0;
  ric_tok_t    tail_q;
  ric_tok_t    out_q;
  logic        out_valid_q;
  logic        busy_q;
  logic        accept;
  logic        finish;
  ric_commit_t commit;

  assign s_axis_tready_o = ~busy_q;
  assign accept          = s_axis_tvalid_i & ~busy_q;
  assign finish          = tail_q.valid & (~out_valid_q | m_axis_tready_i);

  always_comb begin
    tok0            = '0;
    tok0.valid      = accept;
    tok0.action     = s_axis_tuser_i;
    tok0.inum       = s_axis_tdata_i[31:0];
    tok0.slot       = s_axis_tdata_i[37:32];
    tok0.links_zero = s_axis_tdata_i[38];
    unique case (s_axis_tuser_i)
      ACT_GET: tok0.res_status = ST_FULL;
      ACT_RELEASE, ACT_MARK: begin
        tok0.res_status = ST_ERR_MRK;
        tok0.res_slot   = s_axis_tdata_i[37:32];
      end
      default: tok0.res_status = ST_ERR_MRK;
    endcase
  end

  assign chain[0] = tok0;

  for (genvar i = 0; i < CACHE_ENTRIES; i++) begin : g_cell
    ric_cell #(
      .IDX(i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .tok_i   (chain[i]),
      .commit_i(commit),
      .tok_o   (chain[i+1])
    );
  end

  always_comb begin
    commit.en  = finish && tail_q.action == ACT_GET && !tail_q.done && tail_q.free_found;
    commit.tag = tail_q.inum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      tail_q      <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (finish) begin
        busy_q <= 1'b0;
      end
      if (chain[CACHE_ENTRIES].valid) begin
        tail_q <= chain[CACHE_ENTRIES];
      end else if (finish) begin
        tail_q.valid <= 1'b0;
      end
      if (finish) begin
        out_q       <= tail_q;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q.res_refs, out_q.res_nl, out_q.res_slot};
  assign m_axis_tuser_o  = out_q.res_status;

endmodule

`default_nettype wire

### bench/refcounted_inode_cache_table_unit_tb.sv
`default_nettype none

module refcounted_inode_cache_table_unit_tb;
  import ric_pkg::*;

  localparam int unsigned ENTRIES     = 64;
  localparam logic [1:0]  ACT_NONE    = 2'd3;
  localparam int unsigned POOL_SIZE   = 24;
  localparam int unsigned HOLD_CYCLES = 700;
  localparam int unsigned LIMIT       = 400000;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] inum;
    logic [5:0]  slot;
    logic        lz;
  } req_t;

  typedef struct packed {
    logic [5:0]  slot;
    logic [2:0]  status;
    logic        nl;
    logic [15:0] refs;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  // shadow copy of the table
  logic [31:0] shadow_tag    [ENTRIES];
  logic [15:0] shadow_refs   [ENTRIES];
  logic        shadow_loaded [ENTRIES];

  req_t        request_q [$];
  reply_t      reply_q [$];
  req_t        cur_req;
  reply_t      want;
  int unsigned req_taken = 0;
  int unsigned replies_seen = 0;
  int unsigned hold_left = 0;
  bit          held = 1'b0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  refcounted_inode_cache_table_unit #(
    .CACHE_ENTRIES(ENTRIES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic reply_t apply_request(req_t r);
    reply_t o;
    bit     hit;
    bit     have_free;
    int     free_i;
    o = '0;
    hit = 1'b0;
    have_free = 1'b0;
    free_i = 0;
    case (r.action)
      ACT_GET: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!hit && shadow_refs[i] != 0 && shadow_tag[i] == r.inum) begin
            hit = 1'b1;
            if (shadow_refs[i] != REFS_MAX) shadow_refs[i] = shadow_refs[i] + 16'd1;
            o.slot = 6'(i);
            o.status = ST_HIT;
            o.nl = !shadow_loaded[i];
            o.refs = shadow_refs[i];
          end
          if (!hit && !have_free && shadow_refs[i] == 0) begin
            have_free = 1'b1;
            free_i = i;
          end
        end
        if (!hit) begin
          if (have_free) begin
            shadow_tag[free_i] = r.inum;
            shadow_refs[free_i] = 16'd1;
            shadow_loaded[free_i] = 1'b0;
            o.slot = 6'(free_i);
            o.status = ST_MISS;
            o.nl = 1'b1;
            o.refs = 16'd1;
          end else begin
            o.status = ST_FULL;
          end
        end
      end
      ACT_RELEASE: begin
        o.slot = r.slot;
        if (r.slot >= ENTRIES || shadow_refs[r.slot] == 0) begin
          o.status = ST_ERR_MRK;
        end else begin
          shadow_refs[r.slot] = shadow_refs[r.slot] - 16'd1;
          if (shadow_refs[r.slot] == 0 && shadow_loaded[r.slot] && r.lz) begin
            o.status = ST_RECLAIM;
          end else begin
            o.status = ST_RELEASE;
            o.nl = !shadow_loaded[r.slot];
            o.refs = shadow_refs[r.slot];
          end
        end
      end
      ACT_MARK: begin
        o.slot = r.slot;
        o.status = ST_ERR_MRK;
        if (r.slot < ENTRIES) begin
          shadow_loaded[r.slot] = 1'b1;
          o.refs = shadow_refs[r.slot];
        end
      end
      default: begin
        o.status = ST_ERR_MRK;
      end
    endcase
    return o;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
    end
  endtask

  task automatic push_req(input logic [1:0] action, input logic [31:0] inum,
                          input logic [5:0] slot, input logic lz);
    request_q.push_back('{action: action, inum: inum, slot: slot, lz: lz});
  endtask

  task automatic drain();
    while (request_q.size() != 0 || s_axis_tvalid || reply_q.size() != 0)
      @(negedge clk_i);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        reply_q.push_back(apply_request(cur_req));
        req_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (request_q.size() != 0 &&
            ((req_taken >= 600 && req_taken < 800) || $urandom_range(99) >= 34)) begin
          cur_req = request_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {1'b0, cur_req.lz, cur_req.slot, cur_req.inum};
          s_axis_tuser <= cur_req.action;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // reply monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        replies_seen++;
        if (reply_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected reply, expected none, actual tdata %h tuser %0d",
                   $time, m_axis_tdata, m_axis_tuser);
        end else begin
          want = reply_q.pop_front();
          check_field("result_slot", want.slot, m_axis_tdata[5:0]);
          check_field("needs_load", want.nl, m_axis_tdata[6]);
          check_field("ref_after", want.refs, m_axis_tdata[22:7]);
          check_field("status", want.status, m_axis_tuser);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (replies_seen == 300 && !held) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (replies_seen >= 600 && replies_seen < 800) ||
                         $urandom_range(99) >= 34;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [31:0] pool [POOL_SIZE];
    int unsigned r;
    logic [5:0]  sl;
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_tag[i] = '0;
      shadow_refs[i] = '0;
      shadow_loaded[i] = 1'b0;
    end
    pool[0] = 32'h0;
    pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) pool[i] = $urandom;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: hits, misses, reclaim, errors, reuse of freed entries
    push_req(ACT_GET, 32'h0, 6'd0, 1'b0);
    push_req(ACT_GET, 32'hFFFF_FFFF, 6'd63, 1'b1);
    push_req(ACT_GET, 32'h0, 6'd0, 1'b0);
    push_req(ACT_MARK, 32'h0, 6'd0, 1'b0);
    push_req(ACT_GET, 32'h0, 6'd0, 1'b0);
    push_req(ACT_RELEASE, 32'h0, 6'd0, 1'b1);
    push_req(ACT_RELEASE, 32'h0, 6'd0, 1'b0);
    push_req(ACT_RELEASE, 32'h0, 6'd0, 1'b1);
    push_req(ACT_RELEASE, 32'h0, 6'd0, 1'b1);
    push_req(ACT_GET, 32'h0, 6'd0, 1'b0);
    push_req(ACT_MARK, 32'hFFFF_FFFF, 6'd63, 1'b1);
    push_req(ACT_RELEASE, 32'h0, 6'd63, 1'b1);
    push_req(ACT_NONE, 32'hFFFF_FFFF, 6'd63, 1'b1);
    push_req(ACT_RELEASE, 32'h0, 6'd1, 1'b0);
    push_req(ACT_GET, 32'h1234_5678, 6'd0, 1'b0);
    push_req(ACT_GET, 32'hFFFF_FFFF, 6'd0, 1'b0);
    push_req(ACT_MARK, 32'h0, 6'd2, 1'b0);
    push_req(ACT_RELEASE, 32'h0, 6'd2, 1'b0);
    push_req(ACT_GET, 32'hFFFF_FFFF, 6'd0, 1'b0);
    push_req(ACT_RELEASE, 32'h0, 6'd1, 1'b1);
    push_req(ACT_RELEASE, 32'h0, 6'd0, 1'b1);
    push_req(ACT_RELEASE, 32'h0, 6'd2, 1'b1);
    drain();

    // fill the table past full, then empty it
    for (int i = 0; i < 68; i++) push_req(ACT_GET, $urandom, 6'($urandom), 1'($urandom));
    for (int s = 0; s < ENTRIES; s += 2) push_req(ACT_MARK, $urandom, 6'(s), 1'($urandom));
    for (int s = 0; s < ENTRIES; s++) push_req(ACT_RELEASE, $urandom, 6'(s), 1'($urandom));
    drain();

    for (int chunk = 0; chunk < 4; chunk++) begin
      for (int n = 0; n < 240; n++) begin
        r = $urandom_range(99);
        sl = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(31));
        if (r < 32)
          push_req(ACT_GET, pool[$urandom_range(POOL_SIZE - 1)], sl, 1'($urandom));
        else if (r < 36)
          push_req(ACT_GET, $urandom, sl, 1'($urandom));
        else if (r < 72)
          push_req(ACT_RELEASE, $urandom, sl, 1'($urandom));
        else if (r < 92)
          push_req(ACT_MARK, $urandom, sl, 1'($urandom));
        else
          push_req(ACT_NONE, $urandom, 6'($urandom), 1'($urandom));
      end
      drain();
    end

    repeat (ENTRIES + 10) @(posedge clk_i);
    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
